### design/pipw_pkg.sv
// pipw_pkg: shared codes and control structs for the point-in-polygon winding unit
// no dependencies

package pipw_pkg;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [1:0] REL_OUTSIDE  = 2'd0;
  localparam logic [1:0] REL_INSIDE   = 2'd1;
  localparam logic [1:0] REL_BOUNDARY = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic start;
    logic step;
  } edge_ctl_t;

endpackage

### design/pipw_ifs.sv
// pipw_ifs: valid/ready transaction channels for the winding unit
// no dependencies

interface pipw_in_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;

  modport source (output valid, req_type, coord_x, coord_y, input ready);
  modport sink   (input valid, req_type, coord_x, coord_y, output ready);
endinterface

interface pipw_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] relation;
  logic [1:0] status;

  modport source (output valid, relation, status, input ready);
  modport sink   (input valid, relation, status, output ready);
endinterface

### design/pipw_cell.sv
// pipw_cell: one vertex slot of the rotating vertex chain
// depends on pipw_pkg

module pipw_cell import pipw_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  cell_ctl_t                    ctl,
  input  logic signed [COORD_BITS-1:0] din_x,
  input  logic signed [COORD_BITS-1:0] din_y,
  input  logic signed [COORD_BITS-1:0] nbr_x,
  input  logic signed [COORD_BITS-1:0] nbr_y,
  output logic signed [COORD_BITS-1:0] x,
  output logic signed [COORD_BITS-1:0] y
);

  logic signed [COORD_BITS-1:0] x_r;
  logic signed [COORD_BITS-1:0] y_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r <= din_x;
      y_r <= din_y;
    end else if (ctl.shift) begin
      x_r <= nbr_x;
      y_r <= nbr_y;
    end
  end

  assign x = x_r;
  assign y = y_r;

endmodule

### design/pipw_edge.sv
// pipw_edge: three-stage edge evaluator and winding accumulator
// depends on pipw_pkg

module pipw_edge import pipw_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int SUM_W      = 9
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  edge_ctl_t                    ctl,
  input  logic signed [COORD_BITS-1:0] cur_x,
  input  logic signed [COORD_BITS-1:0] cur_y,
  input  logic signed [COORD_BITS-1:0] last_x,
  input  logic signed [COORD_BITS-1:0] last_y,
  input  logic signed [COORD_BITS-1:0] pt_x,
  input  logic signed [COORD_BITS-1:0] pt_y,
  output logic                         boundary,
  output logic                         wind_nz
);

  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * D;

  function automatic logic [1:0] quad(input logic left, input logic below);
    logic [1:0] q;
    if (left) q = below ? 2'd2 : 2'd1;
    else      q = below ? 2'd3 : 2'd0;
    return q;
  endfunction

  logic signed [COORD_BITS-1:0] px_r, py_r, lx_r, ly_r;

  logic                  s1_vld_r;
  logic [1:0]            s1_chg_r;
  logic                  s1_eq_r, s1_box_r;
  logic signed [D-1:0]   s1_dcx_r, s1_dpy_r, s1_dcy_r, s1_dpx_r;

  logic                  s2_vld_r;
  logic [1:0]            s2_chg_r;
  logic                  s2_eq_r, s2_box_r;
  logic signed [P-1:0]   a_r, b_r;

  logic                  bnd_r;
  logic signed [SUM_W-1:0] sum_r;

  logic [1:0]            lq, cq, chg;
  logic                  eq, in_x, in_y;
  logic signed [SUM_W-1:0] delta;

  always_comb begin
    lq   = quad(lx_r < px_r, ly_r < py_r);
    cq   = quad(cur_x < px_r, cur_y < py_r);
    chg  = lq - cq;
    eq   = (cur_x == px_r) && (cur_y == py_r);
    in_x = ((lx_r <= px_r) && (px_r <= cur_x)) || ((cur_x <= px_r) && (px_r <= lx_r));
    in_y = ((ly_r <= py_r) && (py_r <= cur_y)) || ((cur_y <= py_r) && (py_r <= ly_r));
  end

  always_comb begin
    case (s2_chg_r)
      2'd1:    delta = SUM_W'(1);
      2'd3:    delta = -SUM_W'(1);
      2'd2:    delta = (s2_box_r && (a_r > b_r)) ? -SUM_W'(2) : SUM_W'(2);
      default: delta = '0;
    endcase
  end

  // payload: query point, previous vertex, stage data
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      px_r <= pt_x;
      py_r <= pt_y;
      lx_r <= last_x;
      ly_r <= last_y;
    end else if (ctl.step) begin
      lx_r <= cur_x;
      ly_r <= cur_y;
    end
    s1_chg_r <= chg;
    s1_eq_r  <= eq;
    s1_box_r <= in_x && in_y;
    s1_dcx_r <= D'(cur_x) - D'(lx_r);
    s1_dpy_r <= D'(py_r) - D'(ly_r);
    s1_dcy_r <= D'(cur_y) - D'(ly_r);
    s1_dpx_r <= D'(px_r) - D'(lx_r);
    s2_chg_r <= s1_chg_r;
    s2_eq_r  <= s1_eq_r;
    s2_box_r <= s1_box_r;
    a_r      <= P'(s1_dcx_r) * P'(s1_dpy_r);
    b_r      <= P'(s1_dcy_r) * P'(s1_dpx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      bnd_r    <= 1'b0;
      sum_r    <= '0;
    end else begin
      s1_vld_r <= ctl.step;
      s2_vld_r <= s1_vld_r;
      if (ctl.start) begin
        bnd_r <= 1'b0;
        sum_r <= '0;
      end else if (s2_vld_r && !bnd_r) begin
        if (s2_eq_r || (s2_box_r && (a_r == b_r))) begin
          bnd_r <= 1'b1;
        end else begin
          sum_r <= sum_r + delta;
        end
      end
    end
  end

  assign boundary = bnd_r;
  assign wind_nz  = (sum_r != '0);

endmodule

### design/point_in_polygon_winding_unit.sv
// point_in_polygon_winding_unit: top level, vertex chain, edge evaluator and sequencer
// depends on pipw_pkg, pipw_ifs, pipw_cell, pipw_edge

// Append and clear transactions complete without a walk; their result is
// registered on acceptance. A query on a non-empty polygon walks the vertex
// chain: it rotates once all the way round, presenting one vertex per cycle to
// the edge evaluator, and the three-stage evaluator pipeline then drains. The
// chain is back in store order when the query finishes. Only one transaction
// is in flight at a time; a new one is taken once the block is idle and the
// result register is free or being emptied.

module point_in_polygon_winding_unit import pipw_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pipw_in_if.sink     in_ch,
  pipw_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int SUM_W = $clog2(MAX_VERTICES) + 3;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN, ST_FINISH} state_t;

  state_t                       state_r;
  logic [CNT_W-1:0]             count_r;
  logic [IDX_W-1:0]             walk_r;
  logic                         drain_r;
  logic                         out_valid_r;
  logic [1:0]                   rel_r, stat_r;
  logic signed [COORD_BITS-1:0] last_x_r, last_y_r;

  logic signed [COORD_BITS-1:0] cell_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] cell_y [MAX_VERTICES];

  logic      in_fire, out_free, full, append_ok, out_set;
  edge_ctl_t ectl;
  logic      bnd, wind_nz;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign full      = (count_r == CNT_W'(MAX_VERTICES));
  assign append_ok = in_fire && (in_ch.req_type == REQ_APPEND) && !full;

  // a result is produced now unless a walk starts, or at the end of a walk once the result register is free
  assign out_set = (in_fire && !((in_ch.req_type == REQ_QUERY) && (count_r != '0)))
                   || ((state_r == ST_FINISH) && out_free);

  assign in_ch.ready     = (state_r == ST_IDLE) && out_free;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.relation = rel_r;
  assign out_ch.status   = stat_r;

  assign ectl.start = in_fire && (in_ch.req_type == REQ_QUERY);
  assign ectl.step  = (state_r == ST_WALK) && (CNT_W'(walk_r) < count_r);

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    cell_ctl_t cctl;
    assign cctl.shift = (state_r == ST_WALK);
    assign cctl.load  = append_ok && (count_r == CNT_W'(i));
    pipw_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk   (clk),
      .ctl   (cctl),
      .din_x (in_ch.coord_x),
      .din_y (in_ch.coord_y),
      .nbr_x (cell_x[(i + 1) % MAX_VERTICES]),
      .nbr_y (cell_y[(i + 1) % MAX_VERTICES]),
      .x     (cell_x[i]),
      .y     (cell_y[i])
    );
  end

  pipw_edge #(.COORD_BITS(COORD_BITS), .SUM_W(SUM_W)) u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ectl),
    .cur_x    (cell_x[0]),
    .cur_y    (cell_y[0]),
    .last_x   (last_x_r),
    .last_y   (last_y_r),
    .pt_x     (in_ch.coord_x),
    .pt_y     (in_ch.coord_y),
    .boundary (bnd),
    .wind_nz  (wind_nz)
  );

  // last appended vertex closes the polygon
  always_ff @(posedge clk) begin
    if (append_ok) begin
      last_x_r <= in_ch.coord_x;
      last_y_r <= in_ch.coord_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      walk_r      <= '0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
      rel_r       <= REL_OUTSIDE;
      stat_r      <= STAT_OK;
    end else begin
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_ch.req_type)
              REQ_APPEND: begin
                rel_r <= REL_OUTSIDE;
                if (full) begin
                  stat_r <= STAT_FULL;
                end else begin
                  stat_r  <= STAT_OK;
                  count_r <= count_r + CNT_W'(1);
                end
              end
              REQ_QUERY: begin
                if (count_r == '0) begin
                  rel_r  <= REL_OUTSIDE;
                  stat_r <= STAT_EMPTY;
                end else begin
                  state_r <= ST_WALK;
                  walk_r  <= '0;
                end
              end
              REQ_CLEAR: begin
                rel_r   <= REL_OUTSIDE;
                stat_r  <= STAT_OK;
                count_r <= '0;
              end
              default: begin
                rel_r  <= REL_OUTSIDE;
                stat_r <= STAT_OK;
              end
            endcase
          end
        end
        ST_WALK: begin
          walk_r <= walk_r + IDX_W'(1);
          if (walk_r == IDX_W'(MAX_VERTICES - 1)) begin
            state_r <= ST_DRAIN;
            drain_r <= 1'b0;
          end
        end
        ST_DRAIN: begin
          drain_r <= 1'b1;
          if (drain_r) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            stat_r  <= STAT_OK;
            rel_r   <= bnd ? REL_BOUNDARY : (wind_nz ? REL_INSIDE : REL_OUTSIDE);
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_query_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.req_type == REQ_QUERY) && (count_r != '0)) |=> (state_r == ST_WALK))
    else $error("query on a loaded polygon did not start the walk");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.req_type == REQ_APPEND) && full) |=> ($stable(count_r) && out_valid_r
      && (stat_r == STAT_FULL)))
    else $error("append on a full store changed the count or was not flagged");

  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_WALK) && (walk_r == IDX_W'(MAX_VERTICES - 1))) |=> (state_r == ST_DRAIN))
    else $error("walk did not end after a full rotation");

  a_no_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_WALK) |-> !ectl.step)
    else $error("edge step outside of the walk");

endmodule
